/* rtl/xfd_pkg.sv */
// xfd_pkg: shared types, opcode patterns and decode functions of the
// 8086 instruction field decoder. Depends on nothing; used by the channel
// interfaces and the top level.
package xfd_pkg;

    // operation codes
    localparam logic [1:0] OP_MOV = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_CMP = 2'd3;

    // instruction forms
    localparam logic [2:0] FORM_REGMEM_REG = 3'd0;
    localparam logic [2:0] FORM_IMM_REG    = 3'd1;
    localparam logic [2:0] FORM_IMM_REGMEM = 3'd2;
    localparam logic [2:0] FORM_MEM_ACC    = 3'd3;
    localparam logic [2:0] FORM_ACC_IMM    = 3'd4;

    // opcode patterns
    localparam logic [5:0] OPC_MOV_RM      = 6'b100010;
    localparam logic [3:0] OPC_MOV_IMM_REG = 4'b1011;
    localparam logic [6:0] OPC_MOV_IMM_RM  = 7'b1100011;
    localparam logic [5:0] OPC_MOV_ACC     = 6'b101000;
    localparam logic [5:0] OPC_GRP80       = 6'b100000;
    localparam logic [7:0] ALU_RM_MASK     = 8'hC4;
    localparam logic [7:0] ALU_RM_MATCH    = 8'h00;
    localparam logic [7:0] ALU_ACC_MASK    = 8'hC6;
    localparam logic [7:0] ALU_ACC_MATCH   = 8'h04;

    // alu group codes in opcode or modrm reg bits
    localparam logic [2:0] GRP_ADD = 3'b000;
    localparam logic [2:0] GRP_SUB = 3'b101;
    localparam logic [2:0] GRP_CMP = 3'b111;

    // mod field codes
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_DIRECT   = 3'b110;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MODRM,
        PH_BYTES
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  form;
        logic        wide;
        logic        direction;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic        imm_signed;
        logic [2:0]  length;
        logic        error;
    } rec_t;

    typedef struct packed {
        logic       known;
        logic [2:0] form;
    } form_info_t;

    function automatic logic alu_group(input logic [2:0] g);
        return (g == GRP_ADD) || (g == GRP_SUB) || (g == GRP_CMP);
    endfunction

    function automatic logic [1:0] op_of_group(input logic [2:0] g);
        logic [1:0] op;
        case (g)
            GRP_ADD: op = OP_ADD;
            GRP_SUB: op = OP_SUB;
            default: op = OP_CMP;
        endcase
        return op;
    endfunction

    function automatic logic is_group80(input logic [7:0] op);
        return op[7:2] == OPC_GRP80;
    endfunction

    function automatic form_info_t form_of(input logic [7:0] op);
        form_info_t fi;
        fi.known = 1'b1;
        fi.form  = FORM_REGMEM_REG;
        if (op[7:2] == OPC_MOV_RM)
            fi.form = FORM_REGMEM_REG;
        else if (op[7:4] == OPC_MOV_IMM_REG)
            fi.form = FORM_IMM_REG;
        else if (op[7:1] == OPC_MOV_IMM_RM)
            fi.form = FORM_IMM_REGMEM;
        else if (op[7:2] == OPC_MOV_ACC)
            fi.form = FORM_MEM_ACC;
        else if (op[7:2] == OPC_GRP80)
            fi.form = FORM_IMM_REGMEM;
        else if ((op & ALU_RM_MASK) == ALU_RM_MATCH)
        begin
            fi.known = alu_group(op[5:3]);
            fi.form  = FORM_REGMEM_REG;
        end
        else if ((op & ALU_ACC_MASK) == ALU_ACC_MATCH)
        begin
            fi.known = alu_group(op[5:3]);
            fi.form  = FORM_ACC_IMM;
        end
        else
            fi.known = 1'b0;
        return fi;
    endfunction

    function automatic logic hdr_two(input logic [2:0] form);
        return (form == FORM_REGMEM_REG) || (form == FORM_IMM_REGMEM);
    endfunction

    function automatic logic [1:0] disp_len(input logic [2:0] form, input logic [7:0] mr);
        logic [1:0] len;
        len = 2'd0;
        if (form == FORM_MEM_ACC)
            len = 2'd2;
        else if (hdr_two(form))
        begin
            unique case (mr[7:6])
                MOD_NO_DISP: len = (mr[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
                MOD_DISP8:   len = 2'd1;
                MOD_DISP16:  len = 2'd2;
                MOD_REG:     len = 2'd0;
            endcase
        end
        return len;
    endfunction

    function automatic logic imm_sext(input logic [7:0] op);
        return is_group80(op) && op[1];
    endfunction

    function automatic logic [1:0] imm_len(input logic [2:0] form, input logic [7:0] op);
        logic [1:0] len;
        len = 2'd0;
        if (form == FORM_IMM_REG)
            len = op[3] ? 2'd2 : 2'd1;
        else if (form == FORM_ACC_IMM)
            len = op[0] ? 2'd2 : 2'd1;
        else if (form == FORM_IMM_REGMEM)
            len = (imm_sext(op) || !op[0]) ? 2'd1 : 2'd2;
        return len;
    endfunction

    function automatic rec_t error_rec(input logic [2:0] len);
        rec_t r;
        r        = '0;
        r.length = len;
        r.error  = 1'b1;
        return r;
    endfunction

    function automatic rec_t build_rec(
        input logic [7:0]  op,
        input logic [7:0]  mr,
        input logic [15:0] disp,
        input logic [15:0] imm,
        input logic [2:0]  needed
    );
        rec_t       r;
        form_info_t fi;
        logic [1:0] dl;
        logic [1:0] il;
        fi = form_of(op);
        dl = disp_len(fi.form, mr);
        il = imm_len(fi.form, op);
        r = '0;
        r.form = fi.form;
        r.wide = (fi.form == FORM_IMM_REG) ? op[3] : op[0];
        if (fi.form == FORM_REGMEM_REG && !op[7])
            r.operation = op_of_group(op[5:3]);
        if (fi.form == FORM_ACC_IMM)
            r.operation = op_of_group(op[5:3]);
        if (fi.form == FORM_IMM_REGMEM && is_group80(op))
            r.operation = op_of_group(mr[5:3]);
        if (fi.form == FORM_REGMEM_REG || fi.form == FORM_MEM_ACC)
            r.direction = op[1];
        if (hdr_two(fi.form))
        begin
            r.mode     = mr[7:6];
            r.rm_field = mr[2:0];
        end
        if (fi.form == FORM_REGMEM_REG)
            r.reg_field = mr[5:3];
        if (fi.form == FORM_IMM_REG)
            r.reg_field = op[2:0];
        if (dl == 2'd1)
            r.displacement = {{8{disp[7]}}, disp[7:0]};
        else if (dl == 2'd2)
            r.displacement = disp;
        if (il == 2'd1)
        begin
            if (imm_sext(op))
            begin
                r.imm_signed = 1'b1;
                r.immediate  = {{8{imm[7]}}, imm[7:0]};
            end
            else
                r.immediate = {8'h00, imm[7:0]};
        end
        else if (il == 2'd2)
            r.immediate = imm;
        r.length = needed;
        return r;
    endfunction

endpackage

/* rtl/xfd_if.sv */
// xfd_if: valid/ready channel interfaces of the instruction field decoder,
// one for the byte stream and one for decoded records. Depends on xfd_pkg.
interface xfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface xfd_rec_if
    import xfd_pkg::*;
;
    logic valid;
    logic ready;
    rec_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/x86_16_instruction_field_decoder.sv */
// x86_16_instruction_field_decoder: decodes mov, add, sub and cmp
// instructions of the 8086 from a byte stream into field records.
// Depends on xfd_pkg and the channel interfaces in xfd_if.
//
// Usage:
//   stream  - one instruction byte per item, valid/ready handshake.
//   decoded - one record per complete instruction, or an error record
//             for an unknown opcode or an unknown 80-83 extension.
//   One byte is taken every cycle while stream.ready is high; each byte updates the field registers
//   in a single pass of short decode logic, so throughput is one byte per
//   cycle while the second record register is free. A record is registered and
//   shown on decoded from the output register, after waiting in the second record register if the receiver stalls.
//   A second record register behind the output register absorbs a record
//   while the receiver stalls; stream.ready drops only while it is full.
//   Bytes that complete nothing keep flowing while a record waits in the output register.
//   Reset (rst_n low, asynchronous) drops any partly collected instruction
//   and both records, and the decoder waits for an opcode.
module x86_16_instruction_field_decoder
    import xfd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    xfd_byte_if.sink stream,
    xfd_rec_if.source decoded
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [2:0]  seen_reg, seen_next;
    logic [2:0]  needed_reg, needed_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    rec_t        out_reg, out_next;
    rec_t        skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        take;
    logic        emit;
    logic        pop;
    rec_t        rec;
    form_info_t  fi_in;
    form_info_t  fi_op;
    logic [1:0]  dl_cur;
    logic [1:0]  dl_mr;
    logic [1:0]  il_op;
    logic [2:0]  k;
    logic [2:0]  seen_inc;

    assign stream.ready  = !skid_valid_reg;
    assign take          = stream.valid && stream.ready;
    assign pop           = out_valid_reg && decoded.ready;
    assign decoded.valid = out_valid_reg;
    assign decoded.data  = out_reg;

    always_comb
    begin
        fi_in    = form_of(stream.in_byte);
        fi_op    = form_of(opcode_reg);
        dl_cur   = disp_len(fi_op.form, modrm_reg);
        dl_mr    = disp_len(fi_op.form, stream.in_byte);
        il_op    = imm_len(fi_op.form, opcode_reg);
        k        = seen_reg - (hdr_two(fi_op.form) ? 3'd2 : 3'd1);
        seen_inc = seen_reg + 3'd1;

        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        seen_next   = seen_reg;
        needed_next = needed_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        emit        = 1'b0;
        rec         = '0;

        if (take)
        begin
            unique case (phase_reg)
                PH_MODRM:
                begin
                    if (is_group80(opcode_reg) && !alu_group(stream.in_byte[5:3]))
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        rec        = error_rec(3'd2);
                    end
                    else
                    begin
                        modrm_next  = stream.in_byte;
                        seen_next   = 3'd2;
                        needed_next = 3'd2 + {1'b0, dl_mr} + {1'b0, il_op};
                        disp_next   = '0;
                        imm_next    = '0;
                        if (needed_next <= 3'd2)
                        begin
                            phase_next = PH_IDLE;
                            emit       = 1'b1;
                            rec        = build_rec(opcode_reg, stream.in_byte, 16'h0000,
                                                   16'h0000, needed_next);
                        end
                        else
                            phase_next = PH_BYTES;
                    end
                end
                PH_BYTES:
                begin
                    if (k < {1'b0, dl_cur})
                    begin
                        if (k == 3'd0)
                            disp_next = {8'h00, stream.in_byte};
                        else
                            disp_next = {stream.in_byte, disp_reg[7:0]};
                    end
                    else
                    begin
                        if (k == {1'b0, dl_cur})
                            imm_next = {8'h00, stream.in_byte};
                        else
                            imm_next = {stream.in_byte, imm_reg[7:0]};
                    end
                    seen_next = seen_inc;
                    if (seen_inc >= needed_reg)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        rec        = build_rec(opcode_reg, modrm_reg, disp_next, imm_next,
                                               needed_reg);
                    end
                end
                default:
                begin
                    if (!fi_in.known)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        rec        = error_rec(3'd1);
                    end
                    else
                    begin
                        opcode_next = stream.in_byte;
                        modrm_next  = '0;
                        seen_next   = 3'd1;
                        disp_next   = '0;
                        imm_next    = '0;
                        if (hdr_two(fi_in.form))
                        begin
                            needed_next = 3'd2;
                            phase_next  = PH_MODRM;
                        end
                        else
                        begin
                            needed_next = 3'd1
                                + {1'b0, disp_len(fi_in.form, 8'h00)}
                                + {1'b0, imm_len(fi_in.form, stream.in_byte)};
                            phase_next  = PH_BYTES;
                        end
                    end
                end
            endcase
        end
    end

    // output register with a one-record skid behind it
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = emit;
                skid_next       = rec;
            end
            else
            begin
                out_valid_next = emit;
                out_next       = rec;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_next       = rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            opcode_reg     <= '0;
            modrm_reg      <= '0;
            seen_reg       <= '0;
            needed_reg     <= '0;
            disp_reg       <= '0;
            imm_reg        <= '0;
            out_reg        <= '0;
            skid_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            opcode_reg     <= opcode_next;
            modrm_reg      <= modrm_next;
            seen_reg       <= seen_next;
            needed_reg     <= needed_next;
            disp_reg       <= disp_next;
            imm_reg        <= imm_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid record held with empty output register");

    a_error_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.error) |-> (out_reg.length == 3'd1 || out_reg.length == 3'd2))
        else $error("error record with bad length");

    a_record_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.error) |-> (out_reg.length >= 3'd2 && out_reg.length <= 3'd6))
        else $error("decoded record with bad length");

    a_modrm_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MODRM) |-> (fi_op.known && hdr_two(fi_op.form)))
        else $error("modrm phase for an opcode without modrm byte");

    a_bytes_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BYTES) |-> (fi_op.known && seen_reg < needed_reg))
        else $error("collecting bytes past the instruction length");
`endif

endmodule

/* tb/sv/x86_16_instruction_field_decoder_tb.sv */
// x86_16_instruction_field_decoder_tb: feeds byte streams of mov/add/sub/cmp
// instructions, some of them malformed, and checks every decoded record
// against an independent field decoder. Depends on xfd_pkg, xfd_if and the top level.
module x86_16_instruction_field_decoder_tb;
    import xfd_pkg::*;

    localparam int CALM_TAIL = 120;
    localparam int STREAM_BYTES = 650;

    logic clk;
    logic rst_n;

    xfd_byte_if byte_ch ();
    xfd_rec_if rec_ch ();

    x86_16_instruction_field_decoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (byte_ch.sink),
        .decoded (rec_ch.source)
    );

    // opening bytes: unknown opcode, bad 80-83 extension, sign-extended imm8,
    // direct address with ignored reg bits, register-mode c7, disp8, acc forms
    logic [7:0] pending_bytes [$] = {
        8'hFF,
        8'h80, 8'hC8,
        8'h83, 8'hF8, 8'h80,
        8'hC6, 8'h3E, 8'h00, 8'h80, 8'h7F,
        8'hC7, 8'hC0, 8'h00, 8'h80,
        8'h29, 8'h47, 8'h80,
        8'h05, 8'hFF, 8'hFF,
        8'h88, 8'hC1,
        8'hA3, 8'h34, 8'h12
    };

    rec_t expected_records [$];
    int mismatches = 0;
    logic stream_took = 1'b0;
    int gap_left = 0;
    int stall_left = 0;

    // decoder state mirror
    phase_t dec_phase = PH_IDLE;
    logic [7:0] dec_opcode = '0;
    logic [7:0] dec_modrm = '0;
    logic [2:0] dec_seen = '0;
    logic [2:0] dec_needed = '0;
    logic [15:0] dec_disp = '0;
    logic [15:0] dec_imm = '0;

    function automatic logic known_group(input logic [2:0] grp);
        return grp == GRP_ADD || grp == GRP_SUB || grp == GRP_CMP;
    endfunction

    function automatic logic [1:0] group_operation(input logic [2:0] grp);
        case (grp)
            GRP_ADD: return OP_ADD;
            GRP_SUB: return OP_SUB;
            default: return OP_CMP;
        endcase
    endfunction

    function automatic logic [2:0] pick_group();
        case ($urandom_range(0, 2))
            0: return GRP_ADD;
            1: return GRP_SUB;
            default: return GRP_CMP;
        endcase
    endfunction

    function automatic form_info_t opcode_form(input logic [7:0] op);
        form_info_t fi;
        fi = '0;
        if (op[7:2] == OPC_MOV_RM)
        begin
            fi.known = 1'b1;
            fi.form = FORM_REGMEM_REG;
        end
        else if (op[7:4] == OPC_MOV_IMM_REG)
        begin
            fi.known = 1'b1;
            fi.form = FORM_IMM_REG;
        end
        else if (op[7:1] == OPC_MOV_IMM_RM || op[7:2] == OPC_GRP80)
        begin
            fi.known = 1'b1;
            fi.form = FORM_IMM_REGMEM;
        end
        else if (op[7:2] == OPC_MOV_ACC)
        begin
            fi.known = 1'b1;
            fi.form = FORM_MEM_ACC;
        end
        else if (op[7:6] == 2'b00 && !op[2])
        begin
            fi.known = known_group(op[5:3]);
            fi.form = FORM_REGMEM_REG;
        end
        else if (op[7:6] == 2'b00 && op[2:1] == 2'b10)
        begin
            fi.known = known_group(op[5:3]);
            fi.form = FORM_ACC_IMM;
        end
        return fi;
    endfunction

    function automatic logic has_modrm(input logic [2:0] form);
        return form == FORM_REGMEM_REG || form == FORM_IMM_REGMEM;
    endfunction

    function automatic int disp_bytes(input logic [2:0] form, input logic [7:0] mr);
        if (form == FORM_MEM_ACC)
            return 2;
        if (!has_modrm(form))
            return 0;
        case (mr[7:6])
            MOD_NO_DISP: return (mr[2:0] == RM_DIRECT) ? 2 : 0;
            MOD_DISP8:   return 1;
            MOD_DISP16:  return 2;
            default:     return 0;
        endcase
    endfunction

    function automatic logic sext_imm8(input logic [7:0] op);
        return op[7:2] == OPC_GRP80 && op[1];
    endfunction

    function automatic int imm_bytes(input logic [2:0] form, input logic [7:0] op);
        case (form)
            FORM_IMM_REG:    return op[3] ? 2 : 1;
            FORM_ACC_IMM:    return op[0] ? 2 : 1;
            FORM_IMM_REGMEM: return (sext_imm8(op) || !op[0]) ? 1 : 2;
            default:         return 0;
        endcase
    endfunction

    function automatic rec_t decoded_record();
        rec_t r;
        form_info_t fi;
        int dl;
        int il;
        fi = opcode_form(dec_opcode);
        dl = disp_bytes(fi.form, dec_modrm);
        il = imm_bytes(fi.form, dec_opcode);
        r = '0;
        r.form = fi.form;
        r.wide = (fi.form == FORM_IMM_REG) ? dec_opcode[3] : dec_opcode[0];
        case (fi.form)
            FORM_REGMEM_REG:
            begin
                if (!dec_opcode[7])
                    r.operation = group_operation(dec_opcode[5:3]);
                r.direction = dec_opcode[1];
                r.mode = dec_modrm[7:6];
                r.reg_field = dec_modrm[5:3];
                r.rm_field = dec_modrm[2:0];
            end
            FORM_IMM_REG:
                r.reg_field = dec_opcode[2:0];
            FORM_IMM_REGMEM:
            begin
                if (dec_opcode[7:2] == OPC_GRP80)
                    r.operation = group_operation(dec_modrm[5:3]);
                r.mode = dec_modrm[7:6];
                r.rm_field = dec_modrm[2:0];
            end
            FORM_MEM_ACC:
                r.direction = dec_opcode[1];
            FORM_ACC_IMM:
                r.operation = group_operation(dec_opcode[5:3]);
            default:
                r.operation = OP_MOV;
        endcase
        if (dl == 1)
            r.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
        else if (dl == 2)
            r.displacement = dec_disp;
        if (il == 1)
        begin
            r.imm_signed = sext_imm8(dec_opcode);
            r.immediate = r.imm_signed ? {{8{dec_imm[7]}}, dec_imm[7:0]} : {8'h00, dec_imm[7:0]};
        end
        else if (il == 2)
            r.immediate = dec_imm;
        r.length = dec_needed;
        return r;
    endfunction

    task automatic push_fault(input logic [2:0] len);
        rec_t r;
        r = '0;
        r.length = len;
        r.error = 1'b1;
        dec_phase = PH_IDLE;
        expected_records.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        form_info_t fi;
        int dl;
        int k;
        case (dec_phase)
            PH_MODRM:
            begin
                fi = opcode_form(dec_opcode);
                if (dec_opcode[7:2] == OPC_GRP80 && !known_group(b[5:3]))
                    push_fault(3'd2);
                else
                begin
                    dec_modrm = b;
                    dec_seen = 3'd2;
                    dec_needed = 3'(2 + disp_bytes(fi.form, b) + imm_bytes(fi.form, dec_opcode));
                    dec_disp = '0;
                    dec_imm = '0;
                    if (dec_seen >= dec_needed)
                    begin
                        dec_phase = PH_IDLE;
                        expected_records.push_back(decoded_record());
                    end
                    else
                        dec_phase = PH_BYTES;
                end
            end
            PH_BYTES:
            begin
                fi = opcode_form(dec_opcode);
                dl = disp_bytes(fi.form, dec_modrm);
                k = int'(dec_seen) - (has_modrm(fi.form) ? 2 : 1);
                if (k < dl)
                begin
                    if (k == 0)
                        dec_disp = {8'h00, b};
                    else
                        dec_disp[15:8] = b;
                end
                else if (k == dl)
                    dec_imm = {8'h00, b};
                else
                    dec_imm[15:8] = b;
                dec_seen = dec_seen + 3'd1;
                if (dec_seen >= dec_needed)
                begin
                    dec_phase = PH_IDLE;
                    expected_records.push_back(decoded_record());
                end
            end
            default:
            begin
                fi = opcode_form(b);
                if (!fi.known)
                    push_fault(3'd1);
                else
                begin
                    dec_opcode = b;
                    dec_modrm = '0;
                    dec_seen = 3'd1;
                    dec_disp = '0;
                    dec_imm = '0;
                    if (has_modrm(fi.form))
                    begin
                        dec_needed = 3'd2;
                        dec_phase = PH_MODRM;
                    end
                    else
                    begin
                        dec_needed = 3'(1 + disp_bytes(fi.form, 8'h00) + imm_bytes(fi.form, b));
                        dec_phase = PH_BYTES;
                    end
                end
            end
        endcase
    endtask

    // one instruction with random content (an 80-83 one may carry a bad extension), or a stray byte
    task automatic queue_instruction();
        logic [7:0] op;
        logic [7:0] mr;
        form_info_t fi;
        int n;
        if ($urandom_range(0, 99) < 12)
        begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        mr = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: op = {OPC_MOV_RM, 2'($urandom_range(0, 3))};
            1: op = {OPC_MOV_IMM_REG, 4'($urandom_range(0, 15))};
            2: op = {OPC_MOV_IMM_RM, 1'($urandom_range(0, 1))};
            3: op = {OPC_MOV_ACC, 2'($urandom_range(0, 3))};
            4, 5: op = {OPC_GRP80, 2'($urandom_range(0, 3))};
            6, 7: op = {2'b00, pick_group(), 1'b0, 2'($urandom_range(0, 3))};
            default: op = {2'b00, pick_group(), 2'b10, 1'($urandom_range(0, 1))};
        endcase
        if (op[7:2] == OPC_GRP80 && $urandom_range(0, 9) != 0)
            mr[5:3] = pick_group();
        fi = opcode_form(op);
        pending_bytes.push_back(op);
        if (has_modrm(fi.form))
        begin
            pending_bytes.push_back(mr);
            if (op[7:2] == OPC_GRP80 && !known_group(mr[5:3]))
                return;
        end
        n = disp_bytes(fi.form, mr) + imm_bytes(fi.form, op);
        repeat (n)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (!byte_ch.valid || stream_took)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                byte_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                byte_ch.valid <= 1'b1;
                byte_ch.in_byte <= pending_bytes.pop_front();
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 6) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // record receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            rec_ch.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            rec_ch.ready <= 1'b0;
        end
        else
        begin
            rec_ch.ready <= 1'b1;
            if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 6) == 0)
                stall_left = $urandom_range(1, 10);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : monitor
        rec_t want;
        if (!rst_n)
            stream_took = 1'b0;
        else
        begin
            stream_took = byte_ch.valid && byte_ch.ready;
            if (rec_ch.valid && rec_ch.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("decoded record with none expected: %0h", rec_ch.data);
                    mismatches++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    compare_field("operation", 16'(want.operation),
                                  16'(rec_ch.data.operation));
                    compare_field("form", 16'(want.form), 16'(rec_ch.data.form));
                    compare_field("wide", 16'(want.wide), 16'(rec_ch.data.wide));
                    compare_field("direction", 16'(want.direction),
                                  16'(rec_ch.data.direction));
                    compare_field("mode", 16'(want.mode), 16'(rec_ch.data.mode));
                    compare_field("reg_field", 16'(want.reg_field),
                                  16'(rec_ch.data.reg_field));
                    compare_field("rm_field", 16'(want.rm_field),
                                  16'(rec_ch.data.rm_field));
                    compare_field("displacement", want.displacement, rec_ch.data.displacement);
                    compare_field("immediate", want.immediate, rec_ch.data.immediate);
                    compare_field("imm_signed", 16'(want.imm_signed),
                                  16'(rec_ch.data.imm_signed));
                    compare_field("length", 16'(want.length), 16'(rec_ch.data.length));
                    compare_field("error", 16'(want.error), 16'(rec_ch.data.error));
                end
            end
            if (stream_took)
                decode_byte(byte_ch.in_byte);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = '0;
        rec_ch.ready = 1'b0;
        while (pending_bytes.size() < STREAM_BYTES)
            queue_instruction();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || byte_ch.valid)
            @(posedge clk);
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/xfd_pkg.sv
rtl/xfd_if.sv
rtl/x86_16_instruction_field_decoder.sv
tb/sv/x86_16_instruction_field_decoder_tb.sv
